// ===== design/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned FracW = WordW - 2;
    localparam int unsigned SumW = WordW + 3;
    localparam int unsigned RootW = WordW;
    localparam int unsigned DivW = 2 * WordW;

    typedef struct packed {
        logic signed [WordW-1:0] elem_r0c0;
        logic signed [WordW-1:0] elem_r0c1;
        logic signed [WordW-1:0] elem_r0c2;
        logic signed [WordW-1:0] elem_r1c0;
        logic signed [WordW-1:0] elem_r1c1;
        logic signed [WordW-1:0] elem_r1c2;
        logic signed [WordW-1:0] elem_r2c0;
        logic signed [WordW-1:0] elem_r2c1;
        logic signed [WordW-1:0] elem_r2c2;
    } t_in;

    typedef struct packed {
        logic signed [WordW-1:0] quat_w;
        logic signed [WordW-1:0] quat_x;
        logic signed [WordW-1:0] quat_y;
        logic signed [WordW-1:0] quat_z;
        logic [1:0]              largest_index;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        logic [SumW-1:0]         best;
        logic [1:0]              idx;
        logic signed [WordW:0]   num_a;
        logic signed [WordW:0]   num_b;
        logic signed [WordW:0]   num_c;
    } t_job;
endpackage
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_core.sv =====
`default_nettype none
// Channel  | Ports                          | Transaction on
// ---------+--------------------------------+---------------------------
// command  | i_start, o_busy, i_item        | i_start && !o_busy
// result   | o_done, o_result               | every cycle o_done is high
//
// One matrix per cycle; throughput is set by the fully pipelined root and
// dividers (root: one bit per stage, dividers: one quotient bit per stage).
// Order: front, queue, root stages, divider load, divider stages, output register.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// The receiver cannot stall; o_busy is held low so the front never waits.
module rotation_matrix_to_quaternion_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  rmq_pkg::t_in       i_item,
    output logic               o_done,
    output rmq_pkg::t_out      o_result
);
    logic          f_valid;
    rmq_pkg::t_job f_job;

    // front: sum/compare/select
    rmq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_start && !o_busy), .i_item(i_item),
        .o_valid(f_valid), .o_job(f_job)
    );

    // single-entry queue between front and back; back never stalls
    logic          r_qv;
    rmq_pkg::t_job r_qjob;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qv <= 1'b0;
        else          r_qv <= f_valid;
        r_qjob <= f_job;
    end

    rmq_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(r_qv), .i_job(r_qjob),
        .o_valid(o_done), .o_res(o_result)
    );

    assign o_busy = 1'b0;

    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !r_qv)
        else $error("queue valid after reset");
    a_q_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |=> r_qv)
        else $error("queue dropped item");
endmodule
`default_nettype wire

// ===== design/rmq_front.sv =====
`default_nettype none
// classify: trace magnitudes, argmax, numerator pick
module rmq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  rmq_pkg::t_in       i_item,
    output logic               o_valid,
    output rmq_pkg::t_job      o_job
);
    localparam int unsigned W = rmq_pkg::WordW;
    localparam int unsigned S = rmq_pkg::SumW;

    logic signed [S-1:0] a00, a11, a22, one_v;
    logic signed [S-1:0] s0, s1, s2, s3;
    logic [S-1:0] m0, m1, m2, m3, best;
    logic [1:0] idx;
    logic signed [W:0] dx, dy, dz, pxy, pxz, pyz;
    rmq_pkg::t_job n_job, r_job;
    logic r_valid;

    always_comb begin
        a00 = S'(i_item.elem_r0c0);
        a11 = S'(i_item.elem_r1c1);
        a22 = S'(i_item.elem_r2c2);
        one_v = S'(1) <<< rmq_pkg::FracW;
        s0 = one_v + a00 + a11 + a22;
        s1 = one_v + a00 - a11 - a22;
        s2 = one_v - a00 + a11 - a22;
        s3 = one_v - a00 - a11 + a22;
        m0 = s0[S-1] ? S'(-s0) : S'(s0);
        m1 = s1[S-1] ? S'(-s1) : S'(s1);
        m2 = s2[S-1] ? S'(-s2) : S'(s2);
        m3 = s3[S-1] ? S'(-s3) : S'(s3);
        best = m0; idx = 2'd0;
        if (m1 > best) begin best = m1; idx = 2'd1; end
        if (m2 > best) begin best = m2; idx = 2'd2; end
        if (m3 > best) begin best = m3; idx = 2'd3; end
        dx  = (W+1)'(i_item.elem_r1c2) - (W+1)'(i_item.elem_r2c1);
        dy  = (W+1)'(i_item.elem_r2c0) - (W+1)'(i_item.elem_r0c2);
        dz  = (W+1)'(i_item.elem_r0c1) - (W+1)'(i_item.elem_r1c0);
        pxy = (W+1)'(i_item.elem_r0c1) + (W+1)'(i_item.elem_r1c0);
        pxz = (W+1)'(i_item.elem_r0c2) + (W+1)'(i_item.elem_r2c0);
        pyz = (W+1)'(i_item.elem_r1c2) + (W+1)'(i_item.elem_r2c1);
        n_job.best = best;
        n_job.idx = idx;
        unique case (idx)
            2'd0: begin n_job.num_a = dx; n_job.num_b = dy;  n_job.num_c = dz;  end
            2'd1: begin n_job.num_a = dx; n_job.num_b = pxy; n_job.num_c = pxz; end
            2'd2: begin n_job.num_a = dy; n_job.num_b = pxy; n_job.num_c = pyz; end
            default: begin n_job.num_a = dz; n_job.num_b = pxz; n_job.num_c = pyz; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= i_valid;
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job = r_job;
endmodule
`default_nettype wire

// ===== design/rmq_back.sv =====
`default_nettype none
// pipelined root (one bit per stage) then three pipelined restoring dividers
module rmq_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  rmq_pkg::t_job      i_job,
    output logic               o_valid,
    output rmq_pkg::t_out      o_res
);
    localparam int unsigned W = rmq_pkg::WordW;
    localparam int unsigned F = rmq_pkg::FracW;
    localparam int unsigned R = rmq_pkg::RootW;
    localparam int unsigned D = rmq_pkg::DivW;
    localparam int unsigned RW = R + 3;      // root remainder width
    localparam int unsigned VW = 2 * R;      // radicand width
    localparam int unsigned QW = W + 2;      // quotient width, holds saturation
    localparam int unsigned NW = D + 1;      // divider remainder width

    // root pipeline; stage 0 loads the job from the queue
    logic [R:0]          r_rv;
    logic [VW-1:0]       r_rrad [R+1];
    logic [RW-1:0]       r_rrem [R+1];
    logic [R-1:0]        r_root [R+1];
    rmq_pkg::t_job       r_rjob [R+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rv[0] <= 1'b0;
        else          r_rv[0] <= i_valid;
        r_rrad[0] <= VW'(i_job.best) << (F - 2);
        r_rrem[0] <= '0;
        r_root[0] <= '0;
        r_rjob[0] <= i_job;
    end

    for (genvar k = 0; k < R; k++) begin : g_root
        logic [RW-1:0] rem_s, trial;
        always_comb begin
            rem_s = {r_rrem[k][RW-3:0], r_rrad[k][VW-1:VW-2]};
            trial = RW'({r_root[k], 2'b01});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_rv[k+1] <= 1'b0;
            else          r_rv[k+1] <= r_rv[k];
            r_rrad[k+1] <= r_rrad[k] << 2;
            r_rjob[k+1] <= r_rjob[k];
            if (rem_s >= trial) begin
                r_rrem[k+1] <= rem_s - trial;
                r_root[k+1] <= {r_root[k][R-2:0], 1'b1};
            end else begin
                r_rrem[k+1] <= rem_s;
                r_root[k+1] <= {r_root[k][R-2:0], 1'b0};
            end
        end
    end

    // divider pipeline: three lanes, one quotient bit per stage
    logic [D:0]      r_dv;
    logic [R+2:0]    r_den [D+1];
    logic [1:0]      r_idx [D+1];
    logic [R:0]      r_hh  [D+1];
    logic [2:0]      r_neg [D+1];
    logic [D-1:0]    r_num [D+1][3];
    logic [NW-1:0]   r_rem [D+1][3];
    logic [QW-1:0]   r_quo [D+1][3];

    // round h and pick the numerators
    logic [R:0]        h_rnd;
    logic signed [W:0] nums [3];
    always_comb begin
        h_rnd = (r_rrem[R] > RW'(r_root[R])) ? (R+1)'(r_root[R]) + 1'b1
                                              : (R+1)'(r_root[R]);
        nums[0] = r_rjob[R].num_a;
        nums[1] = r_rjob[R].num_b;
        nums[2] = r_rjob[R].num_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r_rv[R];
        r_den[0] <= {h_rnd, 2'b00};
        r_idx[0] <= r_rjob[R].idx;
        r_hh[0]  <= h_rnd;
        for (int l = 0; l < 3; l++) begin
            r_neg[0][l] <= nums[l][W];
            r_num[0][l] <= D'($unsigned(nums[l][W] ? -nums[l] : nums[l])) << F;
            r_rem[0][l] <= '0;
            r_quo[0][l] <= '0;
        end
    end

    for (genvar b = 0; b < D; b++) begin : g_div
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [NW-1:0] rs;
            logic [QW-1:0] qs;
            always_comb begin
                rs = {r_rem[b][l][NW-2:0], r_num[b][l][D-1]};
                qs = (r_quo[b][l] > (QW'(1) << (W-1)))
                     ? (QW'(1) << (W-1)) + 1'b1 : r_quo[b][l];
                qs = qs << 1;
            end
            always_ff @(posedge i_clk) begin
                r_num[b+1][l] <= r_num[b][l] << 1;
                if (rs >= NW'(r_den[b])) begin
                    r_rem[b+1][l] <= rs - NW'(r_den[b]);
                    r_quo[b+1][l] <= qs | QW'(1);
                end else begin
                    r_rem[b+1][l] <= rs;
                    r_quo[b+1][l] <= qs;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[b+1] <= 1'b0;
            else          r_dv[b+1] <= r_dv[b];
            r_den[b+1] <= r_den[b];
            r_idx[b+1] <= r_idx[b];
            r_hh[b+1]  <= r_hh[b];
            r_neg[b+1] <= r_neg[b];
        end
    end

    // rounding, saturation, placement
    function automatic logic [W-1:0] sat(input logic neg, input logic [QW:0] mag);
        logic [QW:0] lim;
        lim = (QW+1)'(1) << (W-1);
        if (neg) return (mag >= lim) ? W'(lim) : W'(-mag);
        return (mag > lim - 1'b1) ? W'(lim - 1'b1) : W'(mag);
    endfunction

    logic [W-1:0] q [3];
    logic [W-1:0] hw;
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [QW:0] m;
            m = (QW+1)'(r_quo[D][l]);
            if (r_rem[D][l] >= NW'(r_den[D]) - r_rem[D][l]) m = m + 1'b1;
            q[l] = (r_den[D] == '0) ? '0 : sat(r_neg[D][l], m);
        end
        hw = sat(1'b0, (QW+1)'(r_hh[D]));
    end

    rmq_pkg::t_out n_res, r_res;
    logic r_ov;
    always_comb begin
        n_res.largest_index = r_idx[D];
        unique case (r_idx[D])
            2'd0: begin n_res.quat_w = hw; n_res.quat_x = q[0];
                        n_res.quat_y = q[1]; n_res.quat_z = q[2]; end
            2'd1: begin n_res.quat_x = hw; n_res.quat_w = q[0];
                        n_res.quat_y = q[1]; n_res.quat_z = q[2]; end
            2'd2: begin n_res.quat_y = hw; n_res.quat_w = q[0];
                        n_res.quat_x = q[1]; n_res.quat_z = q[2]; end
            default: begin n_res.quat_z = hw; n_res.quat_w = q[0];
                        n_res.quat_x = q[1]; n_res.quat_y = q[2]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_dv[D];
        r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== tb/sv/rotation_matrix_to_quaternion_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_to_quaternion_core_tb;
    localparam int WordW = rmq_pkg::WordW;
    localparam int FracW = rmq_pkg::FracW;
    typedef rmq_pkg::t_in  t_in;
    typedef rmq_pkg::t_out t_out;

    localparam int PeriodNs = 8;
    localparam int NumRandom = 1100;
    // pipeline depth of the core; IdleLimit adds headroom
    localparam int Latency = 1 + 1 + (WordW + 1) + 1 + 2 * WordW + 1;
    localparam int IdleLimit = 20 * Latency + 2000;
    localparam logic signed [WordW-1:0] QOne = 1 <<< FracW;
    localparam logic signed [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
    localparam logic signed [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_start = 1'b0;
    logic  o_busy;
    t_in   i_item = '0;
    logic  o_done;
    t_out  o_result;

    int    n_errors = 0;
    int    idle_cycles = 0;

    always #(PeriodNs / 2) i_clk = ~i_clk;

    rotation_matrix_to_quaternion_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                   input logic [WordW-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    // ---- quaternion predictor ----------------------------------------
    // rounded integer sqrt of v, by bisection on a wide type
    function automatic logic [WordW-1:0] round_sqrt(input logic [127:0] v);
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'd1 << WordW;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid;
        end
        // round to nearest: remainder greater than root steps up
        if (v - lo * lo > lo) lo = lo + 1;
        return lo[WordW-1:0];
    endfunction

    function automatic logic [WordW-1:0] clamp_word(input logic neg, input logic [127:0] mag);
        if (neg) return (mag >= (128'd1 << (WordW-1))) ? WordMin : WordW'(-mag);
        return (mag > WordMax) ? WordMax : mag[WordW-1:0];
    endfunction

    // num * 2^F / (4h), nearest with ties away from zero, then saturated
    function automatic logic [WordW-1:0] quarter_quot(input logic signed [WordW+1:0] num,
                                                      input logic [WordW-1:0] h);
        logic         neg;
        logic [127:0] mag, den, quo, rem;
        neg = num < 0;
        mag = neg ? 128'(-num) : 128'(num);
        den = 128'(h) << 2;
        if (den == 0) return '0;
        quo = (mag << FracW) / den;
        rem = (mag << FracW) % den;
        if (rem >= den - rem) quo = quo + 1;
        return clamp_word(neg, quo);
    endfunction

    function automatic t_out predict_quat(input t_in m);
        logic signed [WordW+3:0] s [4];
        logic [WordW+3:0]        best, mag;
        t_branch                 br;
        logic [WordW-1:0]        h, hw;
        logic signed [WordW+1:0] d_x, d_y, d_z, p_xy, p_xz, p_yz;
        t_out                    r;
        s[0] = QOne + m.elem_r0c0 + m.elem_r1c1 + m.elem_r2c2;
        s[1] = QOne + m.elem_r0c0 - m.elem_r1c1 - m.elem_r2c2;
        s[2] = QOne - m.elem_r0c0 + m.elem_r1c1 - m.elem_r2c2;
        s[3] = QOne - m.elem_r0c0 - m.elem_r1c1 + m.elem_r2c2;
        br = BR_W;
        best = '0;
        for (int i = 0; i < 4; i++) begin
            mag = s[i] < 0 ? -s[i] : s[i];
            if (i == 0 || mag > best) begin
                best = mag;
                br = t_branch'(i);
            end
        end
        h = round_sqrt(128'(best) << (FracW - 2));
        hw = clamp_word(1'b0, 128'(h));
        d_x  = m.elem_r1c2 - m.elem_r2c1;
        d_y  = m.elem_r2c0 - m.elem_r0c2;
        d_z  = m.elem_r0c1 - m.elem_r1c0;
        p_xy = m.elem_r0c1 + m.elem_r1c0;
        p_xz = m.elem_r0c2 + m.elem_r2c0;
        p_yz = m.elem_r1c2 + m.elem_r2c1;
        case (br)
            BR_W: begin
                r.quat_w = hw;
                r.quat_x = quarter_quot(d_x, h);
                r.quat_y = quarter_quot(d_y, h);
                r.quat_z = quarter_quot(d_z, h);
            end
            BR_X: begin
                r.quat_x = hw;
                r.quat_w = quarter_quot(d_x, h);
                r.quat_y = quarter_quot(p_xy, h);
                r.quat_z = quarter_quot(p_xz, h);
            end
            BR_Y: begin
                r.quat_y = hw;
                r.quat_w = quarter_quot(d_y, h);
                r.quat_x = quarter_quot(p_xy, h);
                r.quat_z = quarter_quot(p_yz, h);
            end
            default: begin
                r.quat_z = hw;
                r.quat_w = quarter_quot(d_z, h);
                r.quat_x = quarter_quot(p_xz, h);
                r.quat_y = quarter_quot(p_yz, h);
            end
        endcase
        r.largest_index = br;
        return r;
    endfunction

    // ---- scoreboard ---------------------------------------------------
    class quat_scoreboard;
        t_out pending_quats[$];

        function void note_matrix(t_in m);
            pending_quats.push_back(predict_quat(m));
        endfunction

        task check_quat(t_out got);
            t_out want;
            if (pending_quats.size() == 0) begin
                $display("%0t result with no transaction outstanding", $realtime);
                n_errors++;
                return;
            end
            want = pending_quats.pop_front();
            if (got.quat_w !== want.quat_w) report_mismatch("quat_w", got.quat_w, want.quat_w);
            if (got.quat_x !== want.quat_x) report_mismatch("quat_x", got.quat_x, want.quat_x);
            if (got.quat_y !== want.quat_y) report_mismatch("quat_y", got.quat_y, want.quat_y);
            if (got.quat_z !== want.quat_z) report_mismatch("quat_z", got.quat_z, want.quat_z);
            if (got.largest_index !== want.largest_index)
                report_mismatch("largest_index", WordW'(got.largest_index),
                                WordW'(want.largest_index));
        endtask
    endclass

    quat_scoreboard sb = new();

    // sample on the rising edge; stimulus moves on the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_matrix(i_item);
            if (o_done) sb.check_quat(o_result);
            if ((i_start && !o_busy) || o_done) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IdleLimit) begin
                $display("watchdog expired with %0d outstanding", sb.pending_quats.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---- stimulus -----------------------------------------------------
    int burst_left = 0;

    // hold one matrix until accepted; random gaps between bursts
    task automatic send_matrix(input t_in m);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        i_item  <= m;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [WordW-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? WordMax : WordMin;
            default: return $signed(WordW'($urandom)) >>> 1;
        endcase
    endfunction

    // near-rotation: axis-aligned diagonal sign pattern plus jitter, steering every branch
    function automatic t_in rand_rotation();
        t_in m;
        logic signed [WordW-1:0] e [9];
        int k;
        k = $urandom_range(0, 3);
        foreach (e[i]) e[i] = $signed(WordW'($urandom_range(0, 2 ** 22))) - (1 <<< 21);
        if (k == 0) begin
            e[0] += QOne; e[4] += QOne; e[8] += QOne;
        end else begin
            e[0] += (k == 1) ? QOne : -QOne;
            e[4] += (k == 2) ? QOne : -QOne;
            e[8] += (k == 3) ? QOne : -QOne;
        end
        // random element given a large magnitude for depth
        e[$urandom_range(0, 8)] = $signed(WordW'($urandom)) >>> 1;
        m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return m;
    endfunction

    function automatic t_in rand_bits();
        t_in m;
        for (int k = 0; k < 9; k++) m[k*WordW +: WordW] = WordW'($urandom);
        return m;
    endfunction

    function automatic t_in fill_matrix(input logic signed [WordW-1:0] v);
        return {9{v}};
    endfunction

    initial begin
        t_in m;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, each branch, ties, saturation
        send_matrix('0);                   // all four sums tie at one
        send_matrix(fill_matrix(WordMax));
        send_matrix(fill_matrix(WordMin));
        send_matrix({9{32'hFFFF_FFFF}});
        send_matrix({9{32'h5555_5555}});
        send_matrix({9{32'hAAAA_AAAA}});
        send_matrix({QOne, 32'd0, 32'd0, 32'd0, QOne, 32'd0, 32'd0, 32'd0, QOne});
        send_matrix({QOne, 32'd0, 32'd0, 32'd0, -QOne, 32'd0, 32'd0, 32'd0, -QOne});
        send_matrix({-QOne, 32'd0, 32'd0, 32'd0, QOne, 32'd0, 32'd0, 32'd0, -QOne});
        send_matrix({-QOne, 32'd0, 32'd0, 32'd0, -QOne, 32'd0, 32'd0, 32'd0, QOne});
        send_matrix({WordMin, WordMax, WordMin, WordMax, WordMin, WordMax, WordMin,
                     WordMax, WordMin});
        send_matrix({WordMax, WordMin, WordMax, WordMin, WordMax, WordMin, WordMax,
                     WordMin, WordMax});
        send_matrix({32'd0, WordMax, WordMin, WordMin, 32'd0, WordMax, WordMax,
                     WordMin, 32'd0});
        send_matrix({-QOne, WordMax, WordMax, WordMax, -QOne, WordMax, WordMax,
                     WordMax, QOne});
        send_matrix({QOne, WordMin, WordMin, WordMin, 32'd0, WordMin, WordMin,
                     WordMin, -QOne});
        // all four sum magnitudes tie; branch zero wins
        send_matrix({QOne, 32'd7, 32'd0, 32'd0, QOne, 32'd0, 32'd0, 32'd0, -QOne});

        for (int n = 0; n < NumRandom; n++) begin
            if ($urandom_range(0, 3) != 0) m = rand_rotation();
            else m = rand_bits();
            if ($urandom_range(0, 9) == 0) m.elem_r1c2 = rand_word();
            send_matrix(m);
        end
        i_start <= 1'b0;

        while (sb.pending_quats.size() != 0) @(posedge i_clk);
        repeat (Latency + 10) @(posedge i_clk);
        if (n_errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
